// ===== rtl/core/wfos_pkg.sv =====
// package: widths, codes and states for the wall-follow steering unit
`default_nettype none
package wfos_pkg;
    localparam int COORD_BITS_DEF = 20;
    localparam int FRAC_BITS_DEF  = 12;
    localparam int REG_BITS       = 20;
    localparam logic [REG_BITS-1:0] WALL_THR_RST = 20'd9216;
    localparam logic [REG_BITS-1:0] STOP_RAD_RST = 20'd9216;

    typedef enum logic [1:0] {
        CMD_SEGMENT = 2'd0,
        CMD_CIRCLE  = 2'd1,
        CMD_DECIDE  = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        MOT_STOP        = 3'd0,
        MOT_FORWARD     = 3'd1,
        MOT_PIVOT_RIGHT = 3'd2,
        MOT_PIVOT_LEFT  = 3'd3,
        MOT_VEER_RIGHT  = 3'd4,
        MOT_VEER_LEFT   = 3'd5
    } motion_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DOT,
        ST_DEN,
        ST_SEL,
        ST_MULX,
        ST_MHX,
        ST_DIVX,
        ST_MULY,
        ST_MHY,
        ST_DIVY,
        ST_PDX,
        ST_PDY,
        ST_WALL,
        ST_MDX,
        ST_MDY,
        ST_MID,
        ST_OUT
    } state_t;

    localparam int REG_WALL_THR = 0;
    localparam int REG_STOP_RAD = 1;
endpackage
`default_nettype wire

// ===== rtl/core/wfos_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module wfos_div #(
    parameter int W = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  q_reg, q_next;
    logic [W:0]    r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[W-1:0], q_reg[W-1]} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                r_next = trial;
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[W-1:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

// ===== rtl/core/wall_follow_obstacle_steering_unit.sv =====
// top level: obstacle frame reduction and motion decision
//  channel | dir | fields
//  s_axis  | in  | tuser=cmd, tdata=x_first,y_first,x_last,y_last
//  m_axis  | out | tdata=motion
//  apb     | in  | wall_threshold_sq @0, stop_radius_sq @4
// a projected segment makes two passes through the 64-bit serial divider; a clamped
// segment, a circle and a decide do not use the divider.
// one squarer is shared across the distance steps under the sequencer.
// s_axis_tready is low while an item is in work or a result waits on m_axis.
// reset clears the frame state and loads the register defaults.
`default_nettype none
module wall_follow_obstacle_steering_unit #(
    parameter int COORD_BITS = wfos_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = wfos_pkg::FRAC_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // x_first, y_first, x_last, y_last from bit 0 up
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // cmd
    input  wire logic [1:0]                s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // motion
    output logic [7:0]                     m_axis_tdata,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    localparam int CB  = COORD_BITS;
    localparam int DW  = 2 * CB + 2;   // dist squared width
    localparam int PW  = 64;           // product / divider width
    localparam int RB  = wfos_pkg::REG_BITS;

    // config
    logic [RB-1:0] wthr_reg, srad_reg;
    logic          wr;
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wthr_reg <= wfos_pkg::WALL_THR_RST;
            srad_reg <= wfos_pkg::STOP_RAD_RST;
        end
        else if (wr)
        begin
            if (paddr[2] == 1'(wfos_pkg::REG_WALL_THR))
                wthr_reg <= pwdata[RB-1:0];
            else
                srad_reg <= pwdata[RB-1:0];
        end
    end
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == 1'(wfos_pkg::REG_WALL_THR))
            prdata[RB-1:0] = wthr_reg;
        else
            prdata[RB-1:0] = srad_reg;
    end

    // item registers
    logic signed [CB-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [CB:0]   dx_reg, dy_reg;
    logic signed [CB:0]   px_reg, py_reg, px_next, py_next;
    logic signed [2*CB+3:0] dot_reg, dot_next;
    logic [DW-1:0]        den_reg, den_next, acc_reg, acc_next;
    logic [PW-1:0]        num_reg, num_next, prod_reg, prod_next;
    wfos_pkg::cmd_t       cmd_reg;
    wfos_pkg::state_t     st_reg, st_next;

    // frame state
    logic                 stop_reg, stop_next, wseen_reg, wseen_next, mseen_reg, mseen_next;
    logic signed [CB:0]   wx_reg, wx_next, wy_reg, wy_next, mx_reg, mx_next, my_reg, my_next;
    logic [DW-1:0]        wd_reg, wd_next, md_reg, md_next;
    logic [2:0]           mot_reg, mot_next;
    logic                 ov_reg, ov_next;

    // shared squarer
    logic signed [CB+1:0] sq_in;
    logic [CB+1:0]        sq_mag;
    logic [DW-1:0]        sq_out;
    assign sq_mag = sq_in[CB+1] ? (CB+2)'(0) - sq_in : sq_in;
    assign sq_out = DW'(sq_mag[CB:0] * sq_mag[CB:0]);

    // projection product in two halves of num
    logic [CB:0]     mop;
    logic [2*CB+1:0] mlo, mhi;
    assign mlo = mop * num_reg[CB:0];
    assign mhi = mop * num_reg[2*CB+1:CB+1];

    // divider
    logic          dv_start, dv_done;
    logic [PW-1:0] dv_q;
    wfos_div #(.W(PW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start),
        .dividend(prod_next), .divisor(PW'(den_reg)),
        .done(dv_done), .quotient(dv_q)
    );

    logic [CB:0]   adx, ady;
    logic [DW-1:0] wlim, slim;
    logic signed [CB+1:0] sumx, sumy;
    logic [CB:0]   aq;
    logic signed [CB+2:0] aym;
    assign adx  = dx_reg[CB] ? -dx_reg : dx_reg;
    assign ady  = dy_reg[CB] ? -dy_reg : dy_reg;
    assign wlim = DW'({wthr_reg, {FRAC_BITS{1'b0}}});
    assign slim = DW'({srad_reg, {FRAC_BITS{1'b0}}});
    assign sumx = (CB+2)'(x1_reg) + (CB+2)'(x2_reg);
    assign sumy = (CB+2)'(y1_reg) + (CB+2)'(y2_reg);
    assign aq   = dv_q[CB:0];

    localparam logic signed [CB:0] HALF = (CB+1)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [CB:0] ONE  = (CB+1)'(1) <<< FRAC_BITS;

    logic accept;
    assign s_axis_tready = (st_reg == wfos_pkg::ST_IDLE) && !ov_reg;
    assign accept = s_axis_tvalid && s_axis_tready;

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            wfos_pkg::ST_IDLE:
                if (accept)
                begin
                    priority case (wfos_pkg::cmd_t'(s_axis_tuser))
                        wfos_pkg::CMD_SEGMENT: st_next = wfos_pkg::ST_DOT;
                        wfos_pkg::CMD_CIRCLE:  st_next = wfos_pkg::ST_PDX;
                        wfos_pkg::CMD_DECIDE:  st_next = wfos_pkg::ST_OUT;
                        default:               st_next = wfos_pkg::ST_IDLE;
                    endcase
                end
            wfos_pkg::ST_DOT:  st_next = wfos_pkg::ST_DEN;
            wfos_pkg::ST_DEN:  st_next = wfos_pkg::ST_SEL;
            wfos_pkg::ST_SEL:
                if (den_reg == '0 || !dot_reg[2*CB+3] || dot_reg == '0 || num_reg >= PW'(den_reg))
                    st_next = wfos_pkg::ST_PDX;
                else
                    st_next = wfos_pkg::ST_MULX;
            wfos_pkg::ST_MULX: st_next = wfos_pkg::ST_MHX;
            wfos_pkg::ST_MHX:  st_next = wfos_pkg::ST_DIVX;
            wfos_pkg::ST_DIVX: if (dv_done) st_next = wfos_pkg::ST_MULY;
            wfos_pkg::ST_MULY: st_next = wfos_pkg::ST_MHY;
            wfos_pkg::ST_MHY:  st_next = wfos_pkg::ST_DIVY;
            wfos_pkg::ST_DIVY: if (dv_done) st_next = wfos_pkg::ST_PDX;
            wfos_pkg::ST_PDX:  st_next = wfos_pkg::ST_PDY;
            wfos_pkg::ST_PDY:  st_next = wfos_pkg::ST_WALL;
            wfos_pkg::ST_WALL:
                st_next = (cmd_reg == wfos_pkg::CMD_CIRCLE) ? wfos_pkg::ST_IDLE
                                                            : wfos_pkg::ST_MDX;
            wfos_pkg::ST_MDX:  st_next = wfos_pkg::ST_MDY;
            wfos_pkg::ST_MDY:  st_next = wfos_pkg::ST_MID;
            wfos_pkg::ST_MID:  st_next = wfos_pkg::ST_IDLE;
            wfos_pkg::ST_OUT:  st_next = wfos_pkg::ST_IDLE;
            default:           st_next = wfos_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        dot_next = dot_reg; den_next = den_reg; num_next = num_reg; prod_next = prod_reg;
        acc_next = acc_reg; px_next = px_reg; py_next = py_reg;
        stop_next = stop_reg; wseen_next = wseen_reg; mseen_next = mseen_reg;
        wx_next = wx_reg; wy_next = wy_reg; mx_next = mx_reg; my_next = my_reg;
        wd_next = wd_reg; md_next = md_reg; mot_next = mot_reg;
        ov_next = ov_reg && !m_axis_tready;
        dv_start = 1'b0;
        sq_in = '0;
        aym = '0;
        mop = '0;
        unique case (st_reg)
            wfos_pkg::ST_DOT:
            begin
                dot_next = (2*CB+4)'(x1_reg * dx_reg) + (2*CB+4)'(y1_reg * dy_reg);
                sq_in = (CB+2)'(dx_reg);
                den_next = sq_out;
            end
            wfos_pkg::ST_DEN:
            begin
                sq_in = (CB+2)'(dy_reg);
                den_next = den_reg + sq_out;
                num_next = PW'(-dot_reg);
            end
            wfos_pkg::ST_SEL:
            begin
                px_next = (CB+1)'(x1_reg);
                py_next = (CB+1)'(y1_reg);
                if (den_reg != '0 && dot_reg[2*CB+3] && num_reg >= PW'(den_reg))
                begin
                    px_next = (CB+1)'(x2_reg);
                    py_next = (CB+1)'(y2_reg);
                end
            end
            wfos_pkg::ST_MULX:
            begin
                mop = adx;
                prod_next = PW'(mlo) + PW'(den_reg >> 1);
            end
            wfos_pkg::ST_MHX:
            begin
                // divider takes the finished dividend straight from prod_next
                mop = adx;
                prod_next = prod_reg + (PW'(mhi) << (CB + 1));
                dv_start = 1'b1;
            end
            wfos_pkg::ST_DIVX:
                if (dv_done)
                    px_next = dx_reg[CB] ? (CB+1)'(x1_reg) - aq : (CB+1)'(x1_reg) + aq;
            wfos_pkg::ST_MULY:
            begin
                mop = ady;
                prod_next = PW'(mlo) + PW'(den_reg >> 1);
            end
            wfos_pkg::ST_MHY:
            begin
                mop = ady;
                prod_next = prod_reg + (PW'(mhi) << (CB + 1));
                dv_start = 1'b1;
            end
            wfos_pkg::ST_DIVY:
                if (dv_done)
                    py_next = dy_reg[CB] ? (CB+1)'(y1_reg) - aq : (CB+1)'(y1_reg) + aq;
            wfos_pkg::ST_PDX:
            begin
                sq_in = (cmd_reg == wfos_pkg::CMD_CIRCLE) ? (CB+2)'(x1_reg) : (CB+2)'(px_reg);
                acc_next = sq_out;
            end
            wfos_pkg::ST_PDY:
            begin
                sq_in = (cmd_reg == wfos_pkg::CMD_CIRCLE) ? (CB+2)'(y1_reg) : (CB+2)'(py_reg);
                acc_next = acc_reg + sq_out;
            end
            wfos_pkg::ST_WALL:
                if (cmd_reg == wfos_pkg::CMD_CIRCLE)
                begin
                    // rear cone: -x > |y|
                    aym = y1_reg[CB-1] ? -(CB+3)'(y1_reg) : (CB+3)'(y1_reg);
                    if (-(CB+3)'(x1_reg) > aym && acc_reg < slim)
                        stop_next = 1'b1;
                end
                else if (acc_reg < wlim)
                begin
                    if (!wseen_reg || acc_reg < wd_reg)
                    begin
                        wx_next = px_reg; wy_next = py_reg; wd_next = acc_reg;
                    end
                    wseen_next = 1'b1;
                end
            wfos_pkg::ST_MDX:
            begin
                sq_in = (CB+2)'(sumx >>> 1);
                acc_next = sq_out;
            end
            wfos_pkg::ST_MDY:
            begin
                sq_in = (CB+2)'(sumy >>> 1);
                acc_next = acc_reg + sq_out;
            end
            wfos_pkg::ST_MID:
                if (!mseen_reg || acc_reg < md_reg)
                begin
                    mx_next = (CB+1)'(sumx >>> 1);
                    my_next = (CB+1)'(sumy >>> 1);
                    md_next = acc_reg;
                    mseen_next = 1'b1;
                end
            wfos_pkg::ST_OUT:
            begin
                ov_next = 1'b1;
                aym = my_reg[CB] ? -(CB+3)'(my_reg) : (CB+3)'(my_reg);
                if (stop_reg)
                    mot_next = wfos_pkg::MOT_STOP;
                else if (wseen_reg)
                begin
                    if (wx_reg < -HALF && wy_reg > 0)      mot_next = wfos_pkg::MOT_PIVOT_LEFT;
                    else if (wx_reg < -HALF && wy_reg < 0) mot_next = wfos_pkg::MOT_PIVOT_RIGHT;
                    else if (wx_reg > HALF && wy_reg > 0)  mot_next = wfos_pkg::MOT_PIVOT_RIGHT;
                    else if (wx_reg > HALF && wy_reg < 0)  mot_next = wfos_pkg::MOT_PIVOT_LEFT;
                    else if (wy_reg > ONE)                 mot_next = wfos_pkg::MOT_VEER_RIGHT;
                    else if (wy_reg < -ONE)                mot_next = wfos_pkg::MOT_VEER_LEFT;
                    else if (wy_reg > 0 && wy_reg < HALF)  mot_next = wfos_pkg::MOT_VEER_LEFT;
                    else if (wy_reg < 0 && wy_reg > -HALF) mot_next = wfos_pkg::MOT_VEER_RIGHT;
                    else                                   mot_next = wfos_pkg::MOT_FORWARD;
                end
                else if (!mseen_reg)
                    mot_next = wfos_pkg::MOT_PIVOT_RIGHT;
                else if ((CB+3)'(mx_reg) < -(aym <<< 2))
                    mot_next = wfos_pkg::MOT_FORWARD;
                else if (my_reg > 0)
                    mot_next = wfos_pkg::MOT_PIVOT_RIGHT;
                else
                    mot_next = wfos_pkg::MOT_PIVOT_LEFT;
                stop_next = 1'b0; wseen_next = 1'b0; mseen_next = 1'b0;
                wx_next = '0; wy_next = '0; wd_next = '0;
                mx_next = '0; my_next = '0; md_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= wfos_pkg::ST_IDLE;
            stop_reg <= 1'b0; wseen_reg <= 1'b0; mseen_reg <= 1'b0;
            wx_reg <= '0; wy_reg <= '0; wd_reg <= '0;
            mx_reg <= '0; my_reg <= '0; md_reg <= '0;
            ov_reg <= 1'b0;
            mot_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            stop_reg <= stop_next; wseen_reg <= wseen_next; mseen_reg <= mseen_next;
            wx_reg <= wx_next; wy_reg <= wy_next; wd_reg <= wd_next;
            mx_reg <= mx_next; my_reg <= my_next; md_reg <= md_next;
            ov_reg <= ov_next;
            mot_reg <= mot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x1_reg  <= s_axis_tdata[CB-1:0];
            y1_reg  <= s_axis_tdata[2*CB-1:CB];
            x2_reg  <= s_axis_tdata[3*CB-1:2*CB];
            y2_reg  <= s_axis_tdata[4*CB-1:3*CB];
            dx_reg  <= (CB+1)'($signed(s_axis_tdata[3*CB-1:2*CB]))
                     - (CB+1)'($signed(s_axis_tdata[CB-1:0]));
            dy_reg  <= (CB+1)'($signed(s_axis_tdata[4*CB-1:3*CB]))
                     - (CB+1)'($signed(s_axis_tdata[2*CB-1:CB]));
            cmd_reg <= wfos_pkg::cmd_t'(s_axis_tuser);
        end
        dot_reg <= dot_next; den_reg <= den_next; num_reg <= num_next;
        prod_reg <= prod_next; acc_reg <= acc_next;
        px_reg <= px_next; py_reg <= py_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {5'd0, mot_reg};
endmodule
`default_nettype wire

// ===== verif/wall_follow_obstacle_steering_unit_tb.sv =====
// testbench: directed and random obstacle frames against a steering predictor, checked on the output stream
`timescale 1ns / 100ps
module wall_follow_obstacle_steering_unit_tb;

    localparam int CB = 20;
    localparam int FB = 12;
    localparam longint HALF_FX = 64'sd2048;
    localparam longint ONE_FX = 64'sd4096;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        wfos_pkg::cmd_t cmd;
        logic signed [CB-1:0] x1;
        logic signed [CB-1:0] y1;
        logic signed [CB-1:0] x2;
        logic signed [CB-1:0] y2;
    } obstacle_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [4*CB-1:0] s_axis_tdata = '0;  // x_first, y_first, x_last, y_last
    logic [1:0] s_axis_tuser = '0;       // cmd
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // motion
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    wall_follow_obstacle_steering_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 clk = ~clk;

    obstacle_t request_q[$];
    wfos_pkg::motion_t motion_q[$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    bit hold_off = 1'b0;

    // steering state mirror
    longint unsigned wall_thr = 64'(wfos_pkg::WALL_THR_RST);
    longint unsigned stop_rad = 64'(wfos_pkg::STOP_RAD_RST);
    bit stop_seen, wall_seen, mid_seen;
    longint wall_px, wall_py, mid_px, mid_py;
    longint unsigned wall_d2, mid_d2;

    function automatic longint unsigned magn(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned sq_dist(longint x, longint y);
        return magn(x) * magn(x) + magn(y) * magn(y);
    endfunction

    function automatic longint project_axis(longint a, longint d, longint unsigned num,
                                            longint unsigned den);
        longint unsigned q;
        q = (magn(d) * num + den / 2) / den;
        return (d < 0) ? a - longint'(q) : a + longint'(q);
    endfunction

    function automatic void clear_frame();
        stop_seen = 0; wall_seen = 0; mid_seen = 0;
        wall_px = 0; wall_py = 0; wall_d2 = 0;
        mid_px = 0; mid_py = 0; mid_d2 = 0;
    endfunction

    function automatic wfos_pkg::motion_t steering_decision();
        longint x, y, ay;
        if (stop_seen)
            return wfos_pkg::MOT_STOP;
        if (wall_seen)
        begin
            x = wall_px; y = wall_py;
            if (x < -HALF_FX && y > 0) return wfos_pkg::MOT_PIVOT_LEFT;
            if (x < -HALF_FX && y < 0) return wfos_pkg::MOT_PIVOT_RIGHT;
            if (x > HALF_FX && y > 0) return wfos_pkg::MOT_PIVOT_RIGHT;
            if (x > HALF_FX && y < 0) return wfos_pkg::MOT_PIVOT_LEFT;
            if (y > ONE_FX) return wfos_pkg::MOT_VEER_RIGHT;
            if (y < -ONE_FX) return wfos_pkg::MOT_VEER_LEFT;
            if (y > 0 && y < HALF_FX) return wfos_pkg::MOT_VEER_LEFT;
            if (y < 0 && y > -HALF_FX) return wfos_pkg::MOT_VEER_RIGHT;
            return wfos_pkg::MOT_FORWARD;
        end
        if (!mid_seen)
            return wfos_pkg::MOT_PIVOT_RIGHT;
        ay = (mid_py < 0) ? -mid_py : mid_py;
        if (mid_px < -4 * ay) return wfos_pkg::MOT_FORWARD;
        if (mid_py > 0) return wfos_pkg::MOT_PIVOT_RIGHT;
        return wfos_pkg::MOT_PIVOT_LEFT;
    endfunction

    // fold one accepted request into the frame, queue a motion on decide
    function automatic void steer_request(obstacle_t r);
        longint x1, y1, x2, y2, dx, dy, dot, px, py, mx, my;
        longint unsigned den, d2;
        x1 = r.x1; y1 = r.y1; x2 = r.x2; y2 = r.y2;
        case (r.cmd)
            wfos_pkg::CMD_SEGMENT:
            begin
                dx = x2 - x1; dy = y2 - y1;
                dot = x1 * dx + y1 * dy;
                den = sq_dist(dx, dy);
                if (den == 0 || dot >= 0)
                begin
                    px = x1; py = y1;
                end
                else if (longint'(-dot) >= den)
                begin
                    px = x2; py = y2;
                end
                else
                begin
                    px = project_axis(x1, dx, -dot, den);
                    py = project_axis(y1, dy, -dot, den);
                end
                d2 = sq_dist(px, py);
                if (d2 < (wall_thr << FB))
                begin
                    if (!wall_seen || d2 < wall_d2)
                    begin
                        wall_px = px; wall_py = py; wall_d2 = d2;
                    end
                    wall_seen = 1;
                end
                mx = (x1 + x2) >>> 1;
                my = (y1 + y2) >>> 1;
                d2 = sq_dist(mx, my);
                if (!mid_seen || d2 < mid_d2)
                begin
                    mid_px = mx; mid_py = my; mid_d2 = d2; mid_seen = 1;
                end
            end
            wfos_pkg::CMD_CIRCLE:
            begin
                if (-x1 > longint'(magn(y1)) && sq_dist(x1, y1) < (stop_rad << FB))
                    stop_seen = 1;
            end
            wfos_pkg::CMD_DECIDE:
            begin
                motion_q.push_back(steering_decision());
                clear_frame();
            end
            default: ;
        endcase
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin : sender
        obstacle_t r;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                r.cmd = wfos_pkg::cmd_t'(s_axis_tuser);
                {r.y2, r.x2, r.y1, r.x1} = s_axis_tdata;
                steer_request(r);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (request_q.size() == 0 || (!quiet && $urandom_range(99) < 29))
                begin
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    r = request_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= r.cmd;
                    s_axis_tdata <= {r.y2, r.x2, r.y1, r.x1};
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : receiver
        wfos_pkg::motion_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (motion_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected motion %0d", m_axis_tdata);
                end
                else
                begin
                    want = motion_q.pop_front();
                    if (m_axis_tdata != 8'(want))
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("motion mismatch: expected %0d actual %0d",
                                     want, m_axis_tdata);
                    end
                end
            end
            m_axis_tready <= !hold_off && (quiet || $urandom_range(99) >= 29);
        end
    end

    // long receiver hold-off so the block backs up its input
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        hold_off <= (cycles >= 3000 && cycles < 5000);
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic reg_write(input int idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(4 * idx); pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == wfos_pkg::REG_WALL_THR)
            wall_thr = 64'(value & 32'hFFFFF);
        else
            stop_rad = 64'(value & 32'hFFFFF);
    endtask

    task automatic push_req(wfos_pkg::cmd_t c, int a, int b, int e, int f);
        obstacle_t r;
        r.cmd = c; r.x1 = CB'(a); r.y1 = CB'(b); r.x2 = CB'(e); r.y2 = CB'(f);
        request_q.push_back(r);
    endtask

    function automatic int rnd_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 80)
            return $signed($urandom_range(16384)) - 8192;
        if (sel < 95)
            return $signed($urandom_range(65536)) - 32768;
        return $signed(20'($urandom));
    endfunction

    task automatic random_frames(int n);
        int k, len, sel;
        for (k = 0; k < n; k++)
        begin
            len = $urandom_range(6);
            repeat (len)
            begin
                sel = $urandom_range(99);
                if (sel < 65)
                    push_req(wfos_pkg::CMD_SEGMENT, rnd_coord(), rnd_coord(),
                             rnd_coord(), rnd_coord());
                else if (sel < 93)
                    push_req(wfos_pkg::CMD_CIRCLE, rnd_coord(), rnd_coord(),
                             rnd_coord(), rnd_coord());
                else if (sel < 97)
                    push_req(wfos_pkg::CMD_NONE, rnd_coord(), rnd_coord(),
                             rnd_coord(), rnd_coord());
                else
                    push_req(wfos_pkg::CMD_SEGMENT, 0, 0, 0, 0);
            end
            push_req(wfos_pkg::CMD_DECIDE, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
        end
    endtask

    task automatic drain();
        wait (request_q.size() == 0 && !s_axis_tvalid && motion_q.size() == 0);
        // every frame ends in a decide, so wait on after the last one came out, before the next register writes
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        clear_frame();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty frame, extremes, clamps, the rear cone stop and part of the ladder
        push_req(wfos_pkg::CMD_DECIDE, 0, 0, 0, 0);
        push_req(wfos_pkg::CMD_SEGMENT, -524288, -524288, 524287, 524287);
        push_req(wfos_pkg::CMD_SEGMENT, 524287, -524288, -524288, 524287);
        push_req(wfos_pkg::CMD_DECIDE, 0, 0, 0, 0);
        push_req(wfos_pkg::CMD_SEGMENT, 100, 100, 100, 100);              // degenerate
        push_req(wfos_pkg::CMD_SEGMENT, 2000, -6000, 2000, 6000);          // vertical
        push_req(wfos_pkg::CMD_DECIDE, 0, 0, 0, 0);
        push_req(wfos_pkg::CMD_SEGMENT, -6000, -3000, 6000, -3000);        // horizontal
        push_req(wfos_pkg::CMD_SEGMENT, -5000, 5000, -3001, 5000);         // clamp to last
        push_req(wfos_pkg::CMD_DECIDE, 0, 0, 0, 0);
        push_req(wfos_pkg::CMD_SEGMENT, 3000, 1000, 3000, 9000);           // clamp to first
        push_req(wfos_pkg::CMD_DECIDE, 0, 0, 0, 0);
        push_req(wfos_pkg::CMD_SEGMENT, -3000, 1000, -3000, 9000);
        push_req(wfos_pkg::CMD_SEGMENT, -3001, -1, 9000, -20000);          // odd midpoint sum
        push_req(wfos_pkg::CMD_DECIDE, 0, 0, 0, 0);
        push_req(wfos_pkg::CMD_SEGMENT, -40000, 3, -40001, 5);             // midpoint ahead
        push_req(wfos_pkg::CMD_DECIDE, 0, 0, 0, 0);
        push_req(wfos_pkg::CMD_SEGMENT, 40000, -3, 40001, -5);
        push_req(wfos_pkg::CMD_CIRCLE, -4000, 100, 0, 0);                  // rear cone stop
        push_req(wfos_pkg::CMD_CIRCLE, -4000, 4000, 0, 0);                 // cone edge
        push_req(wfos_pkg::CMD_DECIDE, 0, 0, 0, 0);
        push_req(wfos_pkg::CMD_NONE, -4000, 0, 0, 0);
        push_req(wfos_pkg::CMD_SEGMENT, 5000, 1000, -5000, 1000);
        push_req(wfos_pkg::CMD_DECIDE, 0, 0, 0, 0);
        random_frames(150);
        drain();

        reg_write(wfos_pkg::REG_WALL_THR, 32'd0);
        reg_write(wfos_pkg::REG_STOP_RAD, 32'd0);
        random_frames(70);
        drain();

        reg_write(wfos_pkg::REG_WALL_THR, 32'hFFFFF);
        reg_write(wfos_pkg::REG_STOP_RAD, 32'hFFFFF);
        quiet = 1'b1;
        random_frames(120);
        drain();
        quiet = 1'b0;

        reg_write(wfos_pkg::REG_WALL_THR, $urandom_range(32'hFFFFF));
        reg_write(wfos_pkg::REG_STOP_RAD, $urandom_range(40000));
        random_frames(116);
        drain();

        if (motion_q.size() != 0)
            errors++;
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
